// ----- rtl/lpkv_pkg.sv -----
// Shared types and constants for the length-prefixed key/value parser.
// No dependencies; compiled first.
package lpkv_pkg;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_KLEN,
    PH_KEY,
    PH_VLEN,
    PH_VAL,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    K_KEY   = 3'd0,
    K_VAL   = 3'd1,
    K_PEND  = 3'd2,
    K_OK    = 3'd3,
    K_TRUNC = 3'd4
  } kind_t;

  // Result queue: one input byte causes at most three results.
  localparam int MAX_RES   = 3;
  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = $clog2(RES_DEPTH);
  localparam int CNT_W     = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] pair_index;
    logic [15:0] key_length;
    logic [31:0] value_length;
    logic [15:0] pairs_decoded;
    logic        last_of_run;
  } result_t;

endpackage

// ----- rtl/lpkv_ifs.sv -----
// Valid/ready channel interfaces for the key/value parser: byte input and result output.
// Depends on lpkv_pkg.
interface lpkv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface lpkv_out_if;
  import lpkv_pkg::*;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [7:0]  payload_byte;
  logic [15:0] pair_index;
  logic [15:0] key_length;
  logic [31:0] value_length;
  logic [15:0] pairs_decoded;
  logic        last_of_run;

  modport source (output valid, output kind, output payload_byte, output pair_index,
                  output key_length, output value_length, output pairs_decoded,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input payload_byte, input pair_index,
                  input key_length, input value_length, input pairs_decoded,
                  input last_of_run, output ready);
endinterface

// ----- rtl/length_prefixed_kv_parser.sv -----
// Length-prefixed key/value frame parser: takes one frame byte per cycle while ready and
// emits key/value bytes, pair ends and a frame status. Depends on lpkv_pkg, lpkv_ifs.
//
// Usage: each byte is parsed in the cycle it is taken; its results (zero to
// three) go into a four-entry result queue and leave one per cycle while the
// output is ready. A byte is taken whenever the queue holds at most one
// result, so a stream whose bytes cause one result each runs at one byte per
// clock with a steady output; a byte that closes a pair and the frame together
// holds off input while its extra results drain. A frame status closes every
// frame (ok or truncated) and the parser is then back at the start of a new frame.
module length_prefixed_kv_parser (
  input  logic              clk,
  input  logic              rst,
  lpkv_in_if.sink           frame,
  lpkv_out_if.source        result
);
  import lpkv_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  hdr_pos, hdr_pos_next;
  logic [15:0] pair_target, pair_target_next;
  logic [15:0] pairs_done, pairs_done_next;
  logic [15:0] held_key_length, held_key_length_next;
  logic [31:0] held_value_length, held_value_length_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;

  logic        accept;
  logic        pop;
  logic [7:0]  b;
  logic [31:0] rem_dec;
  logic [31:0] vlen_merged;
  logic        emit_data, emit_pend, emit_status, status_ok, finish;
  kind_t       data_kind;
  logic [15:0] pairs_after;

  result_t     res [RES_DEPTH];
  logic [1:0]  res_n;

  result_t     fifo [RES_DEPTH];
  logic [PTR_W-1:0] rd_ptr, wr_ptr;
  logic [CNT_W-1:0] count;

  assign b       = frame.data_byte;
  assign accept  = frame.valid && frame.ready;
  assign pop     = result.valid && result.ready;
  assign rem_dec = bytes_remaining - 32'd1;

  // Room for a worst-case byte in the queue.
  assign frame.ready = (count <= CNT_W'(RES_DEPTH - MAX_RES));

  always_comb begin
    case (hdr_pos)
      2'd0:    vlen_merged = {24'd0, b};
      2'd1:    vlen_merged = held_value_length | {16'd0, b, 8'd0};
      2'd2:    vlen_merged = held_value_length | {8'd0, b, 16'd0};
      default: vlen_merged = held_value_length | {b, 24'd0};
    endcase
  end

  // Next state
  always_comb begin
    phase_next             = phase;
    hdr_pos_next           = hdr_pos;
    pair_target_next       = pair_target;
    pairs_done_next        = pairs_done;
    held_key_length_next   = held_key_length;
    held_value_length_next = held_value_length;
    bytes_remaining_next   = bytes_remaining;
    emit_data              = 1'b0;
    data_kind              = K_KEY;
    finish                 = 1'b0;
    emit_status            = 1'b0;
    status_ok              = 1'b0;

    case (phase)
      PH_COUNT: begin
        if (hdr_pos == 2'd0) begin
          pair_target_next = {8'd0, b};
          hdr_pos_next     = 2'd1;
        end else begin
          pair_target_next = pair_target | {b, 8'd0};
          hdr_pos_next     = 2'd0;
          phase_next       = (pair_target_next == 16'd0) ? PH_DONE : PH_KLEN;
        end
      end
      PH_KLEN: begin
        if (hdr_pos == 2'd0) begin
          held_key_length_next = {8'd0, b};
          hdr_pos_next         = 2'd1;
        end else begin
          held_key_length_next = held_key_length | {b, 8'd0};
          hdr_pos_next         = 2'd0;
          bytes_remaining_next = {16'd0, held_key_length_next};
          phase_next           = (held_key_length_next == 16'd0) ? PH_VLEN : PH_KEY;
        end
      end
      PH_KEY: begin
        emit_data            = 1'b1;
        bytes_remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          hdr_pos_next = 2'd0;
          phase_next   = PH_VLEN;
        end
      end
      PH_VLEN: begin
        held_value_length_next = vlen_merged;
        if (hdr_pos != 2'd3) begin
          hdr_pos_next = hdr_pos + 2'd1;
        end else begin
          hdr_pos_next         = 2'd0;
          bytes_remaining_next = vlen_merged;
          if (vlen_merged == 32'd0) finish = 1'b1;
          else phase_next = PH_VAL;
        end
      end
      PH_VAL: begin
        emit_data            = 1'b1;
        data_kind            = K_VAL;
        bytes_remaining_next = rem_dec;
        if (rem_dec == 32'd0) finish = 1'b1;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    pairs_after = finish ? pairs_done + 16'd1 : pairs_done;
    emit_pend   = finish;
    if (finish) begin
      pairs_done_next = pairs_after;
      hdr_pos_next    = 2'd0;
      phase_next      = (pairs_after == pair_target) ? PH_DONE : PH_KLEN;
    end

    if (frame.frame_last) begin
      emit_status            = 1'b1;
      status_ok              = (phase_next == PH_DONE);
      phase_next             = PH_COUNT;
      hdr_pos_next           = 2'd0;
      pair_target_next       = 16'd0;
      pairs_done_next        = 16'd0;
      held_key_length_next   = 16'd0;
      held_value_length_next = 32'd0;
      bytes_remaining_next   = 32'd0;
    end
  end

  // Results of the current byte, packed in order into res[0..res_n-1]
  always_comb begin
    for (int i = 0; i < RES_DEPTH; i++) res[i] = '0;
    res_n = 2'd0;
    if (emit_data) begin
      res[res_n].kind         = data_kind;
      res[res_n].payload_byte = b;
      res[res_n].pair_index   = pairs_done;
      res_n                   = res_n + 2'd1;
    end
    if (emit_pend) begin
      res[res_n].kind         = K_PEND;
      res[res_n].pair_index   = pairs_done;
      res[res_n].key_length   = held_key_length;
      res[res_n].value_length = (phase == PH_VLEN) ? vlen_merged : held_value_length;
      res_n                   = res_n + 2'd1;
    end
    if (emit_status) begin
      res[res_n].kind          = status_ok ? K_OK : K_TRUNC;
      res[res_n].pairs_decoded = pairs_after;
      res_n                    = res_n + 2'd1;
    end
    if (res_n != 2'd0) res[res_n - 2'd1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_COUNT;
      hdr_pos           <= 2'd0;
      pair_target       <= 16'd0;
      pairs_done        <= 16'd0;
      held_key_length   <= 16'd0;
      held_value_length <= 32'd0;
      bytes_remaining   <= 32'd0;
      rd_ptr            <= '0;
      wr_ptr            <= '0;
      count             <= '0;
    end else begin
      if (accept) begin
        phase             <= phase_next;
        hdr_pos           <= hdr_pos_next;
        pair_target       <= pair_target_next;
        pairs_done        <= pairs_done_next;
        held_key_length   <= held_key_length_next;
        held_value_length <= held_value_length_next;
        bytes_remaining   <= bytes_remaining_next;
        wr_ptr            <= wr_ptr + PTR_W'(res_n);
      end
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + (accept ? CNT_W'(res_n) : CNT_W'(0)) - CNT_W'(pop);
    end
  end

  // Queue storage: entry i takes result (i - wr_ptr) of the accepted byte
  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_DEPTH; i++) begin
      if (accept && ({1'b0, PTR_W'(i) - wr_ptr} < {1'b0, res_n})) begin
        fifo[i] <= res[PTR_W'(i) - wr_ptr];
      end
    end
  end

  assign result.valid         = (count != '0);
  assign result.kind          = fifo[rd_ptr].kind;
  assign result.payload_byte  = fifo[rd_ptr].payload_byte;
  assign result.pair_index    = fifo[rd_ptr].pair_index;
  assign result.key_length    = fifo[rd_ptr].key_length;
  assign result.value_length  = fifo[rd_ptr].value_length;
  assign result.pairs_decoded = fifo[rd_ptr].pairs_decoded;
  assign result.last_of_run   = fifo[rd_ptr].last_of_run;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(RES_DEPTH))
    else $error("result queue overfilled");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && frame.frame_last |=> phase == PH_COUNT && pairs_done == 16'd0)
    else $error("parser not back at frame start after frame status");

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |-> pairs_done == pair_target)
    else $error("frame done with pair count mismatch");

  a_hdr_pos: assert property (@(posedge clk) disable iff (rst)
    phase != PH_VLEN |-> hdr_pos <= 2'd1)
    else $error("header byte position out of range for a 16-bit field");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.kind == K_OK || result.kind == K_TRUNC) |-> result.last_of_run)
    else $error("frame status not marked last of run");

endmodule
